[sv/dwcp_pkg.sv]
// shared types and constants of the dual wavetable crossfade player
// no dependencies; the design files refer to it by scoped names, the testbench imports it

package dwcp_pkg;

    // table depths and the address widths that follow from them
    localparam int unsigned LOOP_DEPTH  = 16384;
    localparam int unsigned START_DEPTH = 65536;
    localparam int unsigned LOOP_AW     = $clog2(LOOP_DEPTH);
    localparam int unsigned START_AW    = $clog2(START_DEPTH);

    // configuration port
    localparam int unsigned CFG_AW = 5;
    localparam int unsigned CFG_DW = 32;

    // reset values
    localparam logic [7:0] VOLUME_RESET       = 8'd200;
    localparam logic [7:0] START_VOLUME_RESET = 8'd255;

    // input word actions
    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_SET    = 3'd1,
        ACT_PLAY   = 3'd2,
        ACT_OFF    = 3'd3,
        ACT_SWITCH = 3'd4,
        ACT_TICK   = 3'd5
    } t_action;

    // table select codes for a load
    typedef enum logic [1:0] {
        TBL_IDLE  = 2'd0,
        TBL_REV   = 2'd1,
        TBL_START = 2'd2
    } t_table;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_HAS_START    = 3'd0,
        REG_IDLE_LENGTH  = 3'd1,
        REG_REV_LENGTH   = 3'd2,
        REG_START_LENGTH = 3'd3,
        REG_START_VOLUME = 3'd4
    } t_reg_idx;

    // configuration register contents
    typedef struct packed {
        logic        has_start;
        logic [14:0] idle_len;
        logic [14:0] rev_len;
        logic [16:0] start_len;
        logic [7:0]  start_vol;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mix_en;
        logic div_en;
        logic scl_en;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic tick_go;
    } t_dp_sts;

endpackage

[sv/dwcp_cfg.sv]
// configuration register file behind the apb-style port
// depends on dwcp_pkg

module dwcp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwcp_pkg::CFG_AW-1:0]   paddr,
    input  logic [dwcp_pkg::CFG_DW-1:0]   pwdata,
    output logic [dwcp_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output dwcp_pkg::t_cfg                o_cfg
);

    dwcp_pkg::t_cfg       r_cfg;
    dwcp_pkg::t_reg_idx   reg_idx;
    logic                 wr_en;

    assign reg_idx = dwcp_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.has_start <= 1'b0;
            r_cfg.idle_len  <= '0;
            r_cfg.rev_len   <= '0;
            r_cfg.start_len <= '0;
            r_cfg.start_vol <= dwcp_pkg::START_VOLUME_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                dwcp_pkg::REG_HAS_START:    r_cfg.has_start <= pwdata[0];
                dwcp_pkg::REG_IDLE_LENGTH:  r_cfg.idle_len  <= pwdata[14:0];
                dwcp_pkg::REG_REV_LENGTH:   r_cfg.rev_len   <= pwdata[14:0];
                dwcp_pkg::REG_START_LENGTH: r_cfg.start_len <= pwdata[16:0];
                dwcp_pkg::REG_START_VOLUME: r_cfg.start_vol <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            dwcp_pkg::REG_HAS_START:    prdata = 32'(r_cfg.has_start);
            dwcp_pkg::REG_IDLE_LENGTH:  prdata = 32'(r_cfg.idle_len);
            dwcp_pkg::REG_REV_LENGTH:   prdata = 32'(r_cfg.rev_len);
            dwcp_pkg::REG_START_LENGTH: prdata = 32'(r_cfg.start_len);
            dwcp_pkg::REG_START_VOLUME: prdata = 32'(r_cfg.start_vol);
            default:                    prdata = '0;
        endcase
    end

endmodule

[sv/dwcp_ctrl.sv]
// controller: sequences one tick through read, crossfade, divide, scale, output
// depends on dwcp_pkg

module dwcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dwcp_pkg::t_dp_sts i_sts,
    output dwcp_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MIX  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SCL  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid & o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = accept;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_sts.tick_go) n_state = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix_en = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                n_state      = ST_SCL;
            end
            ST_SCL: begin
                o_cmd.scl_en = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)  n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/dwcp_dp.sv]
// datapath: sample tables, phase accumulators, crossfade, divide by 255, volume
// depends on dwcp_pkg

module dwcp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dwcp_pkg::t_cfg     i_cfg,
    input  dwcp_pkg::t_dp_cmd  i_cmd,
    output dwcp_pkg::t_dp_sts  o_sts,
    input  logic [2:0]         i_action,
    input  logic [1:0]         i_table_select,
    input  logic [15:0]        i_sample_addr,
    input  logic signed [7:0]  i_sample_value,
    input  logic [19:0]        i_idle_step,
    input  logic [19:0]        i_rev_step,
    input  logic [7:0]         i_mix_amount,
    input  logic [7:0]         i_volume,
    output logic [7:0]         o_dac_sample,
    output logic               o_start_done
);

    // sample tables
    logic [7:0] r_idle_mem  [dwcp_pkg::LOOP_DEPTH];
    logic [7:0] r_rev_mem   [dwcp_pkg::LOOP_DEPTH];
    logic [7:0] r_start_mem [dwcp_pkg::START_DEPTH];

    // control state
    logic [31:0] r_idle_phase;
    logic [31:0] r_rev_phase;
    logic [16:0] r_start_pos;
    logic        r_start_playing;
    logic        r_engine_on;
    logic [19:0] r_idle_inc;
    logic [19:0] r_rev_inc;
    logic [7:0]  r_mix;
    logic [7:0]  r_volume;

    // per-tick working registers
    logic [7:0]         r_idle_rd;
    logic [7:0]         r_rev_rd;
    logic [7:0]         r_start_rd;
    logic               r_use_start;
    logic               r_start_zero;
    logic signed [16:0] r_sum;
    logic signed [7:0]  r_mixed;
    logic signed [16:0] r_prod;
    logic [7:0]         r_dac;
    logic               r_done;

    dwcp_pkg::t_action  action;
    logic               is_tick;

    logic [15:0]                   idle_idx16, rev_idx16;
    logic                          idle_wrap, rev_wrap;
    logic [31:0]                   idle_sel32, rev_sel32;
    logic [dwcp_pkg::LOOP_AW-1:0]  idle_rd_idx, rev_rd_idx;
    logic [31:0]                   idle_base, rev_base;
    logic                          start_ok;
    logic [31:0]                   start_pos32;
    logic [dwcp_pkg::START_AW-1:0] start_rd_idx;
    logic [31:0]                   load_addr32;
    logic                          load_in_loop, load_in_start;
    logic [dwcp_pkg::LOOP_AW-1:0]  load_loop_idx;
    logic [dwcp_pkg::START_AW-1:0] load_start_idx;
    logic                          load_en;

    logic signed [7:0]  iv, rv;
    logic signed [8:0]  diff;
    logic signed [17:0] weighted;
    logic signed [17:0] base;
    logic signed [17:0] sum18;
    logic               neg;
    logic [16:0]        mag;
    logic [16:0]        mag1;
    logic [24:0]        recip;
    logic [8:0]         quot;
    logic [8:0]         quot_s;
    logic signed [7:0]  scl_in;
    logic signed [16:0] prod;

    assign action  = dwcp_pkg::t_action'(i_action);
    assign is_tick = (action == dwcp_pkg::ACT_TICK);
    assign o_sts.tick_go = is_tick && r_engine_on;

    // loop indexes, wrapping at the table length or depth
    always_comb begin
        idle_idx16  = r_idle_phase[31:16];
        rev_idx16   = r_rev_phase[31:16];
        idle_wrap   = (idle_idx16 >= 16'(i_cfg.idle_len)) ||
                      (32'(idle_idx16) >= dwcp_pkg::LOOP_DEPTH);
        rev_wrap    = (rev_idx16 >= 16'(i_cfg.rev_len)) ||
                      (32'(rev_idx16) >= dwcp_pkg::LOOP_DEPTH);
        idle_sel32  = idle_wrap ? 32'd0 : 32'(idle_idx16);
        rev_sel32   = rev_wrap ? 32'd0 : 32'(rev_idx16);
        idle_rd_idx = idle_sel32[dwcp_pkg::LOOP_AW-1:0];
        rev_rd_idx  = rev_sel32[dwcp_pkg::LOOP_AW-1:0];
        idle_base   = idle_wrap ? 32'd0 : r_idle_phase;
        rev_base    = rev_wrap ? 32'd0 : r_rev_phase;
    end

    // start sound position check
    always_comb begin
        start_pos32  = 32'(r_start_pos);
        start_ok     = i_cfg.has_start && (r_start_pos < i_cfg.start_len) &&
                       (start_pos32 < dwcp_pkg::START_DEPTH);
        start_rd_idx = start_pos32[dwcp_pkg::START_AW-1:0];
    end

    // load address decode
    always_comb begin
        load_addr32    = 32'(i_sample_addr);
        load_in_loop   = load_addr32 < dwcp_pkg::LOOP_DEPTH;
        load_in_start  = load_addr32 < dwcp_pkg::START_DEPTH;
        load_loop_idx  = load_addr32[dwcp_pkg::LOOP_AW-1:0];
        load_start_idx = load_addr32[dwcp_pkg::START_AW-1:0];
        load_en        = i_cmd.accept && (action == dwcp_pkg::ACT_LOAD);
    end

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (load_en && load_in_loop &&
            (i_table_select == dwcp_pkg::TBL_IDLE)) begin
            r_idle_mem[load_loop_idx] <= i_sample_value;
        end
        if (load_en && load_in_loop &&
            (i_table_select == dwcp_pkg::TBL_REV)) begin
            r_rev_mem[load_loop_idx] <= i_sample_value;
        end
        if (load_en && load_in_start &&
            (i_table_select == dwcp_pkg::TBL_START)) begin
            r_start_mem[load_start_idx] <= i_sample_value;
        end
        if (i_cmd.accept && o_sts.tick_go) begin
            r_idle_rd  <= r_idle_mem[idle_rd_idx];
            r_rev_rd   <= r_rev_mem[rev_rd_idx];
            r_start_rd <= r_start_mem[start_rd_idx];
        end
    end

    // action handling on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_phase    <= '0;
            r_rev_phase     <= '0;
            r_start_pos     <= '0;
            r_start_playing <= 1'b0;
            r_engine_on     <= 1'b0;
            r_idle_inc      <= '0;
            r_rev_inc       <= '0;
            r_mix           <= '0;
            r_volume        <= dwcp_pkg::VOLUME_RESET;
        end else if (i_cmd.accept) begin
            case (action)
                dwcp_pkg::ACT_SET: begin
                    r_idle_inc <= i_idle_step;
                    r_rev_inc  <= i_rev_step;
                    r_mix      <= i_mix_amount;
                    r_volume   <= i_volume;
                end
                dwcp_pkg::ACT_PLAY: begin
                    r_start_pos     <= '0;
                    r_start_playing <= 1'b1;
                    r_volume        <= i_cfg.start_vol;
                    r_engine_on     <= 1'b1;
                end
                dwcp_pkg::ACT_OFF: begin
                    r_engine_on <= 1'b0;
                end
                dwcp_pkg::ACT_SWITCH: begin
                    r_engine_on  <= 1'b0;
                    r_idle_phase <= '0;
                    r_rev_phase  <= '0;
                    if (r_start_playing) r_start_pos <= '0;
                end
                dwcp_pkg::ACT_TICK: begin
                    if (r_engine_on) begin
                        if (r_start_playing) begin
                            if (start_ok) r_start_pos <= r_start_pos + 17'd1;
                            else          r_start_playing <= 1'b0;
                        end else begin
                            r_idle_phase <= idle_base + 32'(r_idle_inc);
                            r_rev_phase  <= rev_base + 32'(r_rev_inc);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // which source the tick scales
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.tick_go) begin
            r_use_start  <= r_start_playing;
            r_start_zero <= r_start_playing && !start_ok;
        end
    end

    // crossfade: iv*255 + (rv - iv)*mix
    always_comb begin
        iv       = r_idle_rd;
        rv       = r_rev_rd;
        diff     = 9'(rv) - 9'(iv);
        weighted = 18'(diff * $signed({1'b0, r_mix}));
        base     = (18'(iv) <<< 8) - 18'(iv);
        sum18    = base + weighted;
    end

    // divide by 255 toward zero: magnitude plus one, times 257, over 65536
    always_comb begin
        neg    = r_sum[16];
        mag    = neg ? 17'(-r_sum) : 17'(r_sum);
        mag1   = mag + 17'd1;
        recip  = {mag1, 8'd0} + 25'(mag1);
        quot   = recip[24:16];
        quot_s = neg ? -quot : quot;
    end

    // volume scale
    always_comb begin
        if (r_start_zero)     scl_in = '0;
        else if (r_use_start) scl_in = r_start_rd;
        else                  scl_in = r_mixed;
        prod = 17'(scl_in * $signed({1'b0, r_volume}));
    end

    // tick stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_en) r_sum   <= sum18[16:0];
        if (i_cmd.div_en) r_mixed <= quot_s[7:0];
        if (i_cmd.scl_en) r_prod  <= prod;
        if (i_cmd.load_out) begin
            r_dac  <= r_prod[15:8] ^ 8'h80;
            r_done <= !r_start_playing;
        end
    end

    assign o_dac_sample = r_dac;
    assign o_start_done = r_done;

endmodule

[sv/dual_wavetable_crossfade_player_unit.sv]
// top level of the dual wavetable crossfade player
// depends on dwcp_pkg, dwcp_cfg, dwcp_ctrl, dwcp_dp

// A tick word with the engine on passes through the states mix, divide, scale and
// output. The table read happens at the accepting edge. Crossfade, divide by 255
// and volume scale are registered in the mix, divide and scale states; the output
// state hands the word to the output register. The input side is busy during
// those states. It takes the next word in the cycle after the hand-off, even
// while that result still waits there, so a new tick is taken only once the last
// is handed off. While an earlier result still fills the output register, the
// hand-off waits for the receiver to take that word. Every other word (load, set
// controls, play start, turn off, switch, tick with the engine off) leaves the
// input side ready and gives no result. The sample tables come up undefined and
// are not cleared after reset: load every entry that playback can reach.

module dual_wavetable_crossfade_player_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_action,
    input  logic [1:0]                  i_table_select,
    input  logic [15:0]                 i_sample_addr,
    input  logic signed [7:0]           i_sample_value,
    input  logic [19:0]                 i_idle_step,
    input  logic [19:0]                 i_rev_step,
    input  logic [7:0]                  i_mix_amount,
    input  logic [7:0]                  i_volume,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_dac_sample,
    output logic                        o_start_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dwcp_pkg::CFG_AW-1:0] paddr,
    input  logic [dwcp_pkg::CFG_DW-1:0] pwdata,
    output logic [dwcp_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    dwcp_pkg::t_cfg    cfg;
    dwcp_pkg::t_dp_cmd cmd;
    dwcp_pkg::t_dp_sts sts;

    // configuration registers
    dwcp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencing
    dwcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // tables and arithmetic
    dwcp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_table_select (i_table_select),
        .i_sample_addr  (i_sample_addr),
        .i_sample_value (i_sample_value),
        .i_idle_step    (i_idle_step),
        .i_rev_step     (i_rev_step),
        .i_mix_amount   (i_mix_amount),
        .i_volume       (i_volume),
        .o_dac_sample   (o_dac_sample),
        .o_start_done   (o_start_done)
    );

endmodule

[sv/dwcp_checker.sv]
// port-level checks of the dual wavetable crossfade player
// depends on dwcp_pkg; bound to the top level below

module dwcp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [2:0]                  i_action,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [7:0]                  o_dac_sample,
    input logic                        o_start_done,
    input logic                        pready
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_dac_sample) && $stable(o_start_done))
        else $error("output word dropped or changed while stalled");

    // only a tick keeps the input side busy
    a_non_tick_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action != dwcp_pkg::ACT_TICK) |=> o_in_ready)
        else $error("input side busy after a word other than a tick");

    // a word that leaves the input side ready does not raise the result valid
    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready || $stable(o_out_valid) ||
            !o_out_valid)
        else $error("result appeared in the cycle after an accepted word");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready && pready)
        else $error("state after reset is wrong");

endmodule

bind dual_wavetable_crossfade_player_unit dwcp_checker u_dwcp_checker (.*);

[bench/tb_top.sv]
// self-checking testbench of the dual wavetable crossfade player
// depends on dwcp_pkg and dual_wavetable_crossfade_player_unit; a shadow
// player predicts dac words that no directed row fixes; directed rows, then phases

module tb_top;
    import dwcp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 150;
    localparam int RAND_PHASES    = 5;
    localparam int SWEEP_TICKS    = 100;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DIR_ROWS       = 25;

    // codes outside the defined sets
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [1:0] TBL_SPARE  = 2'd3;

    typedef struct packed {
        logic [2:0]  act;
        logic [1:0]  sel;
        logic [15:0] addr;
        logic [7:0]  val;
        logic [19:0] istep;
        logic [19:0] rstep;
        logic [7:0]  mix;
        logic [7:0]  vol;
    } t_word;

    typedef struct packed {
        logic [7:0] dac;
        logic       done;
    } t_res;

    typedef struct packed {
        t_word w;
        logic  typed;
        t_res  res;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [2:0]          i_action;
    logic [1:0]          i_table_select;
    logic [15:0]         i_sample_addr;
    logic signed [7:0]   i_sample_value;
    logic [19:0]         i_idle_step;
    logic [19:0]         i_rev_step;
    logic [7:0]          i_mix_amount;
    logic [7:0]          i_volume;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [7:0]          o_dac_sample;
    logic                o_start_done;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    // shadow player state
    logic [7:0]  idle_mem [LOOP_DEPTH];
    logic [7:0]  rev_mem [LOOP_DEPTH];
    logic [7:0]  start_mem [START_DEPTH];
    bit          idle_wr [LOOP_DEPTH];
    bit          rev_wr [LOOP_DEPTH];
    bit          start_wr [START_DEPTH];
    logic [31:0] idle_acc;
    logic [31:0] rev_acc;
    logic [16:0] start_pos;
    bit          start_on;
    bit          engine_on;
    logic [19:0] idle_inc;
    logic [19:0] rev_inc;
    logic [7:0]  mix_w;
    logic [7:0]  vol_r;
    t_cfg        cfg;

    t_res        dac_q [$];
    t_res        head;
    t_row        dir_tbl [DIR_ROWS];
    int          err_cnt;
    int          stall_cnt;
    int          hold_left;
    bit          hold_req;
    bit          calm;

    dual_wavetable_crossfade_player_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_table_select (i_table_select),
        .i_sample_addr  (i_sample_addr),
        .i_sample_value (i_sample_value),
        .i_idle_step    (i_idle_step),
        .i_rev_step     (i_rev_step),
        .i_mix_amount   (i_mix_amount),
        .i_volume       (i_volume),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_dac_sample   (o_dac_sample),
        .o_start_done   (o_start_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // 128 plus floor of sample times volume over 256, kept to 8 bits
    function automatic logic [7:0] to_dac(int s, logic [7:0] v);
        int          vi;
        logic [31:0] t;
        vi = int'(v);
        t = ((s * vi) >>> 8) + 128;
        return t[7:0];
    endfunction

    // phase index still inside both the table length and the depth
    function automatic bit in_loop(logic [31:0] acc, logic [14:0] len);
        return (acc[31:16] < len) && (acc[31:16] < LOOP_DEPTH);
    endfunction

    function automatic bit start_live();
        return cfg.has_start && (start_pos < cfg.start_len) && (start_pos < START_DEPTH);
    endfunction

    // apply one accepted word to the shadow player
    task automatic play_word(input t_word w, output bit got, output t_res r);
        int iv;
        int rv;
        int mw;
        int mixed;
        got = 1'b0;
        r = '0;
        case (w.act)
            ACT_LOAD: begin
                if (w.sel == TBL_IDLE && w.addr < LOOP_DEPTH) begin
                    idle_mem[w.addr[13:0]] = w.val;
                    idle_wr[w.addr[13:0]] = 1'b1;
                end else if (w.sel == TBL_REV && w.addr < LOOP_DEPTH) begin
                    rev_mem[w.addr[13:0]] = w.val;
                    rev_wr[w.addr[13:0]] = 1'b1;
                end else if (w.sel == TBL_START) begin
                    start_mem[w.addr] = w.val;
                    start_wr[w.addr] = 1'b1;
                end
            end
            ACT_SET: begin
                idle_inc = w.istep;
                rev_inc = w.rstep;
                mix_w = w.mix;
                vol_r = w.vol;
            end
            ACT_PLAY: begin
                start_pos = '0;
                start_on = 1'b1;
                vol_r = cfg.start_vol;
                engine_on = 1'b1;
            end
            ACT_OFF: engine_on = 1'b0;
            ACT_SWITCH: begin
                engine_on = 1'b0;
                idle_acc = '0;
                rev_acc = '0;
                if (start_on) start_pos = '0;
            end
            ACT_TICK: begin
                if (engine_on) begin
                    got = 1'b1;
                    r.dac = 8'd128;
                    if (start_on) begin
                        if (start_live()) begin
                            r.dac = to_dac(int'($signed(start_mem[start_pos[15:0]])), vol_r);
                            start_pos = start_pos + 17'd1;
                        end else begin
                            start_on = 1'b0;
                        end
                    end else begin
                        if (!in_loop(idle_acc, cfg.idle_len)) idle_acc = '0;
                        if (!in_loop(rev_acc, cfg.rev_len)) rev_acc = '0;
                        iv = int'($signed(idle_mem[idle_acc[29:16]]));
                        rv = int'($signed(rev_mem[rev_acc[29:16]]));
                        mw = int'(mix_w);
                        // integer division truncates toward zero
                        mixed = (iv * (255 - mw) + rv * mw) / 255;
                        r.dac = to_dac(mixed, vol_r);
                        idle_acc = idle_acc + {12'd0, idle_inc};
                        rev_acc = rev_acc + {12'd0, rev_inc};
                    end
                    r.done = !start_on;
                end
            end
            default: ;
        endcase
    endtask

    // offer one word, wait for acceptance, then predict
    task automatic send_word(input t_word w, input bit typed, input t_res fixed_res);
        bit   got;
        t_res r;
        if (!calm) begin
            while ($urandom_range(99) < 11) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_action <= w.act;
        i_table_select <= w.sel;
        i_sample_addr <= w.addr;
        i_sample_value <= w.val;
        i_idle_step <= w.istep;
        i_rev_step <= w.rstep;
        i_mix_amount <= w.mix;
        i_volume <= w.vol;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        play_word(w, got, r);
        if (got) dac_q.push_back(typed ? fixed_res : r);
    endtask

    function automatic t_word junk_word(logic [2:0] a);
        t_word w;
        w.act = a;
        w.sel = 2'($urandom_range(3));
        w.addr = 16'($urandom_range(16'hFFFF));
        w.val = 8'($urandom_range(8'hFF));
        w.istep = 20'($urandom_range(20'hFFFFF));
        w.rstep = 20'($urandom_range(20'hFFFFF));
        w.mix = 8'($urandom_range(8'hFF));
        w.vol = 8'($urandom_range(8'hFF));
        return w;
    endfunction

    function automatic logic [19:0] pick_step();
        return ($urandom_range(3) == 0) ? 20'($urandom_range(20'hFFFFF)) :
                                          20'($urandom_range(20'h30000));
    endfunction

    function automatic t_word rand_word();
        t_word w;
        int    n;
        n = $urandom_range(99);
        w = junk_word(ACT_TICK);
        if (n < 55) begin
            // a stopped engine is restarted half the time so ticks reach the mixer
            if (!engine_on && $urandom_range(1) == 1) w.act = ACT_PLAY;
        end else if (n < 67) begin
            w.act = ACT_LOAD;
            w.sel = ($urandom_range(9) == 0) ? TBL_SPARE : 2'($urandom_range(2));
            if (w.sel != TBL_START && $urandom_range(3) != 0) w.addr = 16'($urandom_range(63));
        end else if (n < 77) begin
            w.act = ACT_SET;
            w.istep = pick_step();
            w.rstep = pick_step();
        end else if (n < 83) begin
            w.act = ACT_PLAY;
        end else if (n < 87) begin
            w.act = ACT_OFF;
        end else if (n < 92) begin
            w.act = ACT_SWITCH;
        end else begin
            w.act = ($urandom_range(1) == 1) ? ACT_SPARE6 : ACT_SPARE7;
        end
        return w;
    endfunction

    task automatic load_entry(input logic [1:0] sel, input logic [15:0] addr);
        t_word w;
        w = junk_word(ACT_LOAD);
        w.sel = sel;
        w.addr = addr;
        send_word(w, 1'b0, '0);
    endtask

    // load any entry the next tick would read that still holds nothing
    task automatic fill_reads();
        logic [13:0] ii;
        logic [13:0] ri;
        if (engine_on && start_on) begin
            if (start_live() && !start_wr[start_pos[15:0]]) load_entry(TBL_START, start_pos[15:0]);
        end else if (engine_on) begin
            ii = in_loop(idle_acc, cfg.idle_len) ? idle_acc[29:16] : 14'd0;
            ri = in_loop(rev_acc, cfg.rev_len) ? rev_acc[29:16] : 14'd0;
            if (!idle_wr[ii]) load_entry(TBL_IDLE, {2'b00, ii});
            if (!rev_wr[ri]) load_entry(TBL_REV, {2'b00, ri});
        end
    endtask

    task automatic send_tick();
        fill_reads();
        send_word(junk_word(ACT_TICK), 1'b0, '0);
    endtask

    task automatic drain();
        while (dac_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access; psel stays up between back-to-back writes
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_HAS_START:    cfg.has_start = v[0];
            REG_IDLE_LENGTH:  cfg.idle_len = v[14:0];
            REG_REV_LENGTH:   cfg.rev_len = v[14:0];
            REG_START_LENGTH: cfg.start_len = v[16:0];
            REG_START_VOLUME: cfg.start_vol = v[7:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int has, input int il, input int rl, input int sl, input int sv);
        i_in_valid <= 1'b0;
        drain();
        apb_write(REG_HAS_START, has);
        apb_write(REG_IDLE_LENGTH, il);
        apb_write(REG_REV_LENGTH, rl);
        apb_write(REG_START_LENGTH, sl);
        apb_write(REG_START_VOLUME, sv);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_words(input int n);
        t_word w;
        repeat (n) begin
            w = rand_word();
            if (w.act == ACT_TICK) fill_reads();
            send_word(w, 1'b0, '0);
        end
    endtask

    function automatic t_row dir_row(logic [2:0] a, logic [1:0] s, logic [15:0] ad,
                                     logic [7:0] v, logic [19:0] st_i, logic [19:0] st_r,
                                     logic [7:0] m, logic [7:0] vo, int ty, logic [7:0] d);
        t_row row;
        row.w = '{a, s, ad, v, st_i, st_r, m, vo};
        row.typed = (ty != 0);
        row.res = '{d, 1'b1};
        return row;
    endfunction

    // result side: check each result word taken, stall at random or on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (dac_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected word, expected none, got dac %0d done %0d",
                         $time, o_dac_sample, o_start_done);
            end else begin
                head = dac_q.pop_front();
                if (o_dac_sample !== head.dac) begin
                    err_cnt++;
                    $display("%0t: dac_sample expected %0d got %0d",
                             $time, head.dac, o_dac_sample);
                end
                if (o_start_done !== head.done) begin
                    err_cnt++;
                    $display("%0t: start_done expected %0d got %0d",
                             $time, head.done, o_start_done);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
            (psel && penable))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_TICK;
        i_table_select = TBL_IDLE;
        i_sample_addr = '0;
        i_sample_value = '0;
        i_idle_step = '0;
        i_rev_step = '0;
        i_mix_amount = '0;
        i_volume = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_cnt = 0;
        stall_cnt = 0;
        hold_left = 0;
        hold_req = 1'b0;
        calm = 1'b0;
        idle_acc = '0;
        rev_acc = '0;
        start_pos = '0;
        start_on = 1'b0;
        engine_on = 1'b0;
        idle_inc = '0;
        rev_inc = '0;
        mix_w = '0;
        vol_r = VOLUME_RESET;
        cfg = '0;
        cfg.start_vol = START_VOLUME_RESET;

        // directed rows; default lengths of zero keep every loop read at entry 0
        dir_tbl[0]  = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[1]  = dir_row(ACT_LOAD,   TBL_IDLE,  16'd0,     8'h7F, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[2]  = dir_row(ACT_LOAD,   TBL_REV,   16'd0,     8'h80, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[3]  = dir_row(ACT_LOAD,   TBL_SPARE, 16'd0,     8'h05, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[4]  = dir_row(ACT_LOAD,   TBL_IDLE,  16'd16384, 8'h01, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[5]  = dir_row(ACT_LOAD,   TBL_START, 16'hFFFF,  8'hFF, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[6]  = dir_row(ACT_SPARE6, TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[7]  = dir_row(ACT_PLAY,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        // no start table present: playback ends on the first tick
        dir_tbl[8]  = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 1, 8'd128);
        dir_tbl[9]  = dir_row(ACT_SET,    TBL_IDLE,  16'd0,     8'h00, 20'hFFFFF, 20'h80000, 8'h00, 8'hFF, 0, 8'd0);
        dir_tbl[10] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 1, 8'd254);
        // phases now point past the zero length and fall back to entry 0
        dir_tbl[11] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 1, 8'd254);
        dir_tbl[12] = dir_row(ACT_SET,    TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'hFF, 8'h00, 0, 8'd0);
        dir_tbl[13] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 1, 8'd128);
        dir_tbl[14] = dir_row(ACT_SET,    TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'hFF, 8'hFF, 0, 8'd0);
        dir_tbl[15] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 1, 8'd0);
        dir_tbl[16] = dir_row(ACT_OFF,    TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[17] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[18] = dir_row(ACT_PLAY,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[19] = dir_row(ACT_SWITCH, TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[20] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[21] = dir_row(ACT_PLAY,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);
        dir_tbl[22] = dir_row(ACT_SET,    TBL_IDLE,  16'd0,     8'h00, 20'h01000, 20'h02000, 8'h80, 8'hC8, 0, 8'd0);
        dir_tbl[23] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 1, 8'd128);
        dir_tbl[24] = dir_row(ACT_TICK,   TBL_IDLE,  16'd0,     8'h00, 20'h0,     20'h0,     8'h00, 8'h00, 0, 8'd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) send_word(dir_tbl[k].w, dir_tbl[k].typed, dir_tbl[k].res);

        // short start sound, receiver held off while ticks keep coming
        set_cfg(1, 5, 3, 20, 255);
        hold_req = 1'b1;
        random_words(PHASE_WORDS);

        // nothing present, zero start volume
        set_cfg(0, 0, 0, 0, 0);
        random_words(PHASE_WORDS);

        // maximum steps until the idle phase runs past its length and wraps
        set_cfg(0, 1200, 16384, 131071, 128);
        send_word(junk_word(ACT_PLAY), 1'b0, '0);
        begin
            t_word sw;
            sw = junk_word(ACT_SET);
            sw.istep = 20'hFFFFF;
            sw.rstep = 20'hFFFFF;
            send_word(sw, 1'b0, '0);
        end
        repeat (SWEEP_TICKS) send_tick();

        // random settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            int r;
            int sl;
            r = $urandom_range(4);
            sl = (r == 0) ? 65536 : (r == 1) ? $urandom_range(131071) : $urandom_range(60);
            set_cfg($urandom_range(1),
                    ($urandom_range(4) == 0) ? $urandom_range(32767) : $urandom_range(48),
                    ($urandom_range(4) == 0) ? $urandom_range(32767) : $urandom_range(48),
                    sl, $urandom_range(255));
            random_words(PHASE_WORDS);
        end

        // start sound played through to its end, no idling
        set_cfg(1, $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(60, 90),
                $urandom_range(255));
        calm = 1'b1;
        send_word(junk_word(ACT_PLAY), 1'b0, '0);
        while (start_on) send_tick();
        calm = 1'b0;

        i_in_valid <= 1'b0;
        drain();
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
